>>> rtl/dcpwm_pkg.sv
package dcpwm_pkg;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_TOP      = 3'd0;
	localparam logic [2:0] REG_DUTY_A   = 3'd1;
	localparam logic [2:0] REG_DUTY_B   = 3'd2;
	localparam logic [2:0] REG_MODE     = 3'd3;
	localparam logic [2:0] REG_INVERT   = 3'd4;
	localparam logic [2:0] REG_ENABLE   = 3'd5;
	localparam logic [2:0] REG_PRESCALE = 3'd6;

	localparam logic [1:0] MODE_FAST = 2'd0;

	localparam int TOP_W  = 16;
	localparam int DUTY_W = 7;
	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

	// floor(x / 100) for x below 2^23 is (x * RECIP) >> RECIP_SHIFT.
	localparam int PROD_W      = TOP_W + DUTY_W;
	localparam int RECIP_W     = 24;
	localparam int SCALE_W     = PROD_W + RECIP_W;
	localparam int RECIP_SHIFT = 30;
	localparam logic [RECIP_W-1:0] RECIP = 24'd10737419;

	localparam logic [2:0] PSC_DIV1    = 3'd1;
	localparam logic [2:0] PSC_DIV8    = 3'd2;
	localparam logic [2:0] PSC_DIV64   = 3'd3;
	localparam logic [2:0] PSC_DIV256  = 3'd4;
	localparam logic [2:0] PSC_DIV1024 = 3'd5;

	typedef struct packed {
		logic        running;
		logic [15:0] last;
	} prescale_t;

	// Terminal prescaler count (divisor minus one) for a select code.
	function automatic prescale_t prescale_of(input logic [2:0] sel);
		prescale_t p;
		p.running = 1'b1;
		case (sel)
			PSC_DIV1:    p.last = 16'd0;
			PSC_DIV8:    p.last = 16'd7;
			PSC_DIV64:   p.last = 16'd63;
			PSC_DIV256:  p.last = 16'd255;
			PSC_DIV1024: p.last = 16'd1023;
			default: begin
				p.running = 1'b0;
				p.last    = 16'd0;
			end
		endcase
		return p;
	endfunction

endpackage

>>> rtl/dual_channel_pwm_generator.sv
// Dual-channel PWM timer with a shared counter and two compare channels.
// Input channel (in_valid, in_ready, tick): each beat is one base clock tick;
// tick = 0 holds the timer and still yields a result. Output channel
// (out_valid, out_ready, out_a, out_b, count, counting_down): exactly one
// result beat per input beat, in order, showing the outputs after that tick.
// Configuration channel (cfg_valid, cfg_ready, cfg_addr, cfg_data) is always
// ready and writes one register per beat; the user must see that registers
// are written only while idle, which the block itself does not enforce.
// Throughput: one beat per cycle unless the receiver stalls, set by the
// counter and prescaler step that updates the timer state on every accepted
// beat. The compare values floor(duty * top / 100) are derived from the
// registers through a registered product and a reciprocal multiply, so
// they follow a configuration write via the written and then the product
// register. The stage register plus the output register decouple the sides:
// when the receiver stalls, one more beat is taken into the stage, then
// in_ready drops until out_ready returns. Reset clears all registers, the
// counter, the prescaler and the direction flag, and empties both stages.
module dual_channel_pwm_generator #(
	parameter int COUNTER_WIDTH  = 16,
	parameter int PRESCALE_WIDTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        out_a,
	output logic        out_b,
	output logic [15:0] count,
	output logic        counting_down,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_data
);

	localparam int CW = COUNTER_WIDTH;
	localparam int PW = PRESCALE_WIDTH;
	// Only the low COUNTER_WIDTH bits of the top register take part.
	localparam logic [15:0] TOP_MASK = (CW >= 16) ? 16'hFFFF : 16'((64'd1 << CW) - 64'd1);

	// Configuration registers.
	logic [15:0]                    top_q;
	logic [dcpwm_pkg::DUTY_W-1:0]   duty_a_q;
	logic [dcpwm_pkg::DUTY_W-1:0]   duty_b_q;
	logic [1:0]                     mode_q;
	logic                           invert_q;
	logic [1:0]                     enable_q;
	logic [2:0]                     psel_q;

	// Timer state.
	logic [PW-1:0] prescale_q;
	logic [CW-1:0] counter_q;
	logic          down_q;

	// Stage register between the timer step and the output register.
	logic          valid_s1;
	logic [CW-1:0] counter_s1;
	logic          down_s1;

	logic                          in_fire;
	logic                          adv;
	logic [dcpwm_pkg::DUTY_W-1:0]  duty_clamped;
	logic [15:0]                   top_eff;
	logic [CW-1:0]                 top_cw;
	dcpwm_pkg::prescale_t          psc;
	logic [PW-1:0]                 psc_last;
	logic                          step;
	logic [PW-1:0]                 prescale_n;
	logic [CW-1:0]                 counter_n;
	logic                          down_n;
	logic [15:0]                   cmp_a;
	logic [15:0]                   cmp_b;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || out_ready;
	assign in_ready  = !valid_s1 || adv;
	assign in_fire   = in_valid && in_ready;

	// A duty write keeps its low seven bits and saturates at one hundred.
	assign duty_clamped = (cfg_data[6:0] > dcpwm_pkg::DUTY_MAX) ? dcpwm_pkg::DUTY_MAX
		: cfg_data[6:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q    <= '0;
			duty_a_q <= '0;
			duty_b_q <= '0;
			mode_q   <= '0;
			invert_q <= 1'b0;
			enable_q <= '0;
			psel_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				dcpwm_pkg::REG_TOP:      top_q    <= cfg_data;
				dcpwm_pkg::REG_DUTY_A:   duty_a_q <= duty_clamped;
				dcpwm_pkg::REG_DUTY_B:   duty_b_q <= duty_clamped;
				dcpwm_pkg::REG_MODE:     mode_q   <= cfg_data[1:0];
				dcpwm_pkg::REG_INVERT:   invert_q <= cfg_data[0];
				dcpwm_pkg::REG_ENABLE:   enable_q <= cfg_data[1:0];
				dcpwm_pkg::REG_PRESCALE: psel_q   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign top_eff  = top_q & TOP_MASK;
	assign top_cw   = CW'(top_eff);
	assign psc      = dcpwm_pkg::prescale_of(psel_q);
	assign psc_last = PW'(psc.last);

	// Prescaler and counter step for one tick. A prescale count at or past
	// the terminal value (possible after a select change) wraps and steps.
	always_comb begin
		prescale_n = prescale_q;
		counter_n  = counter_q;
		down_n     = down_q;
		step       = 1'b0;
		if (tick && psc.running) begin
			if (prescale_q >= psc_last) begin
				prescale_n = '0;
				step       = 1'b1;
			end else begin
				prescale_n = prescale_q + 1'b1;
			end
		end
		if (step) begin
			if (mode_q == dcpwm_pkg::MODE_FAST) begin
				// Single slope: wrap at top; a counter above top runs on to
				// the full-width wrap.
				down_n    = 1'b0;
				counter_n = (counter_q == top_cw) ? '0 : counter_q + 1'b1;
			end else if (!down_q) begin
				// Rising: turn at top, or at once when already above it.
				if (counter_q >= top_cw) begin
					if (counter_q != '0) begin
						down_n    = 1'b1;
						counter_n = counter_q - 1'b1;
					end
				end else begin
					counter_n = counter_q + 1'b1;
				end
			end else begin
				// Falling: turn at zero; with top at zero the counter stays put.
				if (counter_q == '0) begin
					down_n    = 1'b0;
					counter_n = (top_cw != '0) ? CW'(1) : '0;
				end else begin
					counter_n = counter_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q <= '0;
			counter_q  <= '0;
			down_q     <= 1'b0;
			valid_s1   <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				prescale_q <= prescale_n;
				counter_q  <= counter_n;
				down_q     <= down_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			counter_s1 <= counter_n;
			down_s1    <= down_n;
		end
	end

	dcpwm_compare u_cmp_a (
		.clk    (clk),
		.arst_n (arst_n),
		.duty   (duty_a_q),
		.top    (top_eff),
		.cmp    (cmp_a)
	);

	dcpwm_compare u_cmp_b (
		.clk    (clk),
		.arst_n (arst_n),
		.duty   (duty_b_q),
		.top    (top_eff),
		.cmp    (cmp_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= valid_s1;
		end
	end

	// The compare values never exceed the masked top, so they fit the counter
	// width exactly. A disabled channel drives 0 whatever the inversion.
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_a         <= enable_q[0] && ((counter_s1 < CW'(cmp_a)) ^ invert_q);
			out_b         <= enable_q[1] && ((counter_s1 < CW'(cmp_b)) ^ invert_q);
			count         <= 16'(counter_s1);
			counting_down <= down_s1;
		end
	end

`ifndef ASSERT_OFF
	// Timer state moves only on an accepted beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(counter_q) && $stable(prescale_q) && $stable(down_q))
		else $error("timer state changed without an accepted beat");

	// A stopped prescaler freezes the counter even on ticks.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !psc.running |=> $stable(counter_q) && $stable(prescale_q))
		else $error("stopped timer advanced");

	// A single-slope step always leaves the direction flag clear.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && step && mode_q == dcpwm_pkg::MODE_FAST |=> !down_q)
		else $error("direction flag set in fast mode");

	// A falling dual-slope step moves the counter down by exactly one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && step && mode_q != dcpwm_pkg::MODE_FAST && down_q && counter_q != '0
		|=> counter_q == $past(counter_q) - 1'b1)
		else $error("falling counter did not step by one");
`endif

endmodule

>>> rtl/dcpwm_compare.sv
module dcpwm_compare (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [dcpwm_pkg::DUTY_W-1:0]       duty,
	input  logic [dcpwm_pkg::TOP_W-1:0]        top,
	output logic [dcpwm_pkg::TOP_W-1:0]        cmp
);

	localparam int SW = dcpwm_pkg::SCALE_W;

	logic [dcpwm_pkg::PROD_W-1:0] prod_q;
	logic [SW-1:0]                scaled;

	// The product is registered so that only one multiplier sits in each path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else begin
			prod_q <= dcpwm_pkg::PROD_W'(duty) * dcpwm_pkg::PROD_W'(top);
		end
	end

	assign scaled = SW'(prod_q) * SW'(dcpwm_pkg::RECIP);
	assign cmp    = scaled[dcpwm_pkg::RECIP_SHIFT +: dcpwm_pkg::TOP_W];

endmodule

>>> tb/sv/tb.sv
module tb;

	// Mode and prescaler codes that the package leaves unnamed.
	localparam logic [1:0] MODE_PHASE      = 2'd1;
	localparam logic [1:0] MODE_PHASE_FREQ = 2'd2;
	localparam logic [1:0] MODE_SPARE      = 2'd3;
	localparam logic [2:0] PSC_OFF         = 3'd0;
	localparam logic [2:0] PSC_SPARE6      = 3'd6;
	localparam logic [2:0] PSC_SPARE7      = 3'd7;

	// Number of random ticks before the stimulus moves on to the closing run.
	localparam int RANDOM_TICKS = 1700;

	// One result beat as the block presents it.
	typedef struct packed {
		logic        a;
		logic        b;
		logic [15:0] cnt;
		logic        down;
	} pwm_result_t;

	// The scoreboard keeps its own copy of the timer registers and state. Every
	// accepted tick advances that copy and queues the levels the block must show;
	// every result beat is compared against the oldest queued entry.
	class pwm_scoreboard;
		logic [15:0] top_value;
		logic [6:0]  duty_a;
		logic [6:0]  duty_b;
		logic [1:0]  wave_mode;
		logic        invert;
		logic [1:0]  enables;
		logic [2:0]  prescale_sel;
		logic [9:0]  prescale_count;
		logic [15:0] counter;
		logic        down_flag;
		pwm_result_t expected_levels[$];
		int          errors;
		int          checked;

		function new();
			top_value      = '0;
			duty_a         = '0;
			duty_b         = '0;
			wave_mode      = dcpwm_pkg::MODE_FAST;
			invert         = 1'b0;
			enables        = '0;
			prescale_sel   = PSC_OFF;
			prescale_count = '0;
			counter        = '0;
			down_flag      = 1'b0;
			errors         = 0;
			checked        = 0;
		endfunction

		function logic [6:0] clamp_duty(logic [6:0] d);
			return (d > dcpwm_pkg::DUTY_MAX) ? dcpwm_pkg::DUTY_MAX : d;
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				dcpwm_pkg::REG_TOP:      top_value = data;
				dcpwm_pkg::REG_DUTY_A:   duty_a = clamp_duty(data[6:0]);
				dcpwm_pkg::REG_DUTY_B:   duty_b = clamp_duty(data[6:0]);
				dcpwm_pkg::REG_MODE:     wave_mode = data[1:0];
				dcpwm_pkg::REG_INVERT:   invert = data[0];
				dcpwm_pkg::REG_ENABLE:   enables = data[1:0];
				dcpwm_pkg::REG_PRESCALE: prescale_sel = data[2:0];
				default: ;
			endcase
		endfunction

		// A channel is high below floor(duty * top / 100), then inverted and gated.
		function logic level(logic [6:0] duty, logic en);
			logic [31:0] threshold;
			threshold = (32'(duty) * 32'(top_value)) / 32'd100;
			return en & ((32'(counter) < threshold) ^ invert);
		endfunction

		function void step_counter();
			if (wave_mode == dcpwm_pkg::MODE_FAST) begin
				down_flag = 1'b0;
				if (counter == top_value)
					counter = '0;
				else
					counter = counter + 16'd1;
			end else if (!down_flag) begin
				// Rising: turn at top, or at once when a lowered top left us above it.
				if (counter >= top_value) begin
					if (counter != '0) begin
						down_flag = 1'b1;
						counter   = counter - 16'd1;
					end
				end else begin
					counter = counter + 16'd1;
				end
			end else begin
				if (counter == '0) begin
					down_flag = 1'b0;
					if (top_value != '0)
						counter = 16'd1;
				end else begin
					counter = counter - 16'd1;
				end
			end
		endfunction

		function void note_tick(logic t);
			logic        running;
			logic [9:0]  last;
			pwm_result_t r;
			running = 1'b1;
			case (prescale_sel)
				dcpwm_pkg::PSC_DIV1:    last = 10'd0;
				dcpwm_pkg::PSC_DIV8:    last = 10'd7;
				dcpwm_pkg::PSC_DIV64:   last = 10'd63;
				dcpwm_pkg::PSC_DIV256:  last = 10'd255;
				dcpwm_pkg::PSC_DIV1024: last = 10'd1023;
				default: begin
					running = 1'b0;
					last    = '0;
				end
			endcase
			// A count left past a smaller divisor clears on the next counted tick.
			if (t && running) begin
				if (prescale_count >= last) begin
					prescale_count = '0;
					step_counter();
				end else begin
					prescale_count = prescale_count + 10'd1;
				end
			end
			r.a    = level(duty_a, enables[0]);
			r.b    = level(duty_b, enables[1]);
			r.cnt  = counter;
			r.down = down_flag;
			expected_levels.push_back(r);
		endfunction

		function void check_result(pwm_result_t got);
			pwm_result_t want;
			checked++;
			if (expected_levels.size() == 0) begin
				$error("result beat with no tick outstanding (count %0d)", got.cnt);
				errors++;
				return;
			end
			want = expected_levels.pop_front();
			if (got.a !== want.a) begin
				$error("out_a: expected %0d, actual %0d", want.a, got.a);
				errors++;
			end
			if (got.b !== want.b) begin
				$error("out_b: expected %0d, actual %0d", want.b, got.b);
				errors++;
			end
			if (got.cnt !== want.cnt) begin
				$error("count: expected %0d, actual %0d", want.cnt, got.cnt);
				errors++;
			end
			if (got.down !== want.down) begin
				$error("counting_down: expected %0d, actual %0d", want.down, got.down);
				errors++;
			end
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        tick;
	logic        out_valid;
	logic        out_ready;
	logic        out_a;
	logic        out_b;
	logic [15:0] count;
	logic        counting_down;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_addr;
	logic [15:0] cfg_data;

	pwm_scoreboard timer_sb;
	bit            idle_on;
	int            ticks_sent;
	int            random_ticks;
	int            settings;
	logic [15:0]   sweep_len;

	dual_channel_pwm_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.tick         (tick),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_a        (out_a),
		.out_b        (out_b),
		.count        (count),
		.counting_down(counting_down),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_addr     (cfg_addr),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	// Both channels are observed at the same edge. A tick accepted at this edge
	// is queued before any result is checked; its own result cannot appear
	// before a later edge, so the order of the two steps never matters.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			timer_sb.note_tick(tick);
		end
		if (out_valid && out_ready) begin
			timer_sb.check_result({out_a, out_b, count, counting_down});
		end
	end

	// The receiver stalls in random bursts while idling is on and is otherwise
	// always ready. Exactly one assignment to out_ready happens per edge.
	initial begin
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall == 0 && idle_on && $urandom_range(0, 5) == 0)
				stall = $urandom_range(1, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Sends one tick beat. With idling on, a random burst of empty cycles may
	// come first. Valid then stays high with the same payload until accepted.
	task automatic send_tick(input logic t);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		tick     <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ticks_sent++;
	endtask

	// Stops sending and waits until every queued result has come back. The
	// first edge makes sure the last accepted tick has been queued. A closing
	// wait then lets the block's pipeline settle before registers change.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (timer_sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all seven registers in index order once the block is idle. The
	// duty registers go early, so the derived compare values have settled well
	// before the first tick of the new setting.
	task automatic program_timer(input logic [15:0] top, input logic [15:0] da,
			input logic [15:0] db, input logic [15:0] mode, input logic [15:0] inv,
			input logic [15:0] en, input logic [15:0] psc);
		logic [2:0]  idx [7];
		logic [15:0] val [7];
		idx = '{dcpwm_pkg::REG_TOP, dcpwm_pkg::REG_DUTY_A, dcpwm_pkg::REG_DUTY_B,
			dcpwm_pkg::REG_MODE, dcpwm_pkg::REG_INVERT, dcpwm_pkg::REG_ENABLE,
			dcpwm_pkg::REG_PRESCALE};
		val = '{top, da, db, mode, inv, en, psc};
		wait_idle();
		for (int i = 0; i < 7; i++) begin
			cfg_valid <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			timer_sb.write_reg(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Sends n ticks taken from a pattern, least significant bit first.
	task automatic run_ticks(input logic [7:0] pattern, input int n);
		for (int i = 0; i < n; i++)
			send_tick(pattern[i]);
	endtask

	// Now and then sets bits above a register's width; the block must drop them.
	function automatic logic [15:0] noisy(input logic [15:0] v, input int w);
		logic [15:0] mask;
		mask = (16'd1 << w) - 16'd1;
		if ($urandom_range(0, 7) == 0)
			return v | (16'($urandom) & ~mask);
		return v;
	endfunction

	// One random setting followed by n random ticks. Tops are mostly small so
	// that the counter turns and wraps often; prescalers are mostly fast.
	task automatic random_phase(input int n);
		logic [15:0] top;
		logic [1:0]  mode;
		logic [2:0]  psc;
		case ($urandom_range(0, 9))
			0:          top = 16'd0;
			1, 2, 3, 4: top = 16'($urandom_range(1, 8));
			5, 6, 7:    top = 16'($urandom_range(9, 300));
			8:          top = 16'hFFFF;
			default:    top = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mode = dcpwm_pkg::MODE_FAST;
			4, 5, 6:    mode = MODE_PHASE;
			7, 8:       mode = MODE_PHASE_FREQ;
			default:    mode = MODE_SPARE;
		endcase
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5, 6, 7: psc = dcpwm_pkg::PSC_DIV1;
			8, 9, 10:               psc = dcpwm_pkg::PSC_DIV8;
			11:                     psc = dcpwm_pkg::PSC_DIV64;
			12:                     psc = ($urandom_range(0, 1) != 0)
				? dcpwm_pkg::PSC_DIV256 : dcpwm_pkg::PSC_DIV1024;
			13:                     psc = PSC_OFF;
			14:                     psc = PSC_SPARE6;
			default:                psc = PSC_SPARE7;
		endcase
		program_timer(top,
			noisy(16'($urandom_range(0, 127)), 7),
			noisy(16'($urandom_range(0, 127)), 7),
			noisy(16'(mode), 2),
			noisy(16'($urandom_range(0, 1)), 1),
			noisy(16'($urandom_range(0, 3)), 2),
			noisy(16'(psc), 3));
		for (int i = 0; i < n; i++)
			send_tick($urandom_range(0, 6) != 0);
		random_ticks += n;
	endtask

	initial begin
		timer_sb     = new();
		idle_on      = 1'b0;
		ticks_sent   = 0;
		random_ticks = 0;
		settings     = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		tick      <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_addr  <= dcpwm_pkg::REG_TOP;
		cfg_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the prescaler is stopped: ticks, held or not, change nothing.
		run_ticks(8'b0000_0101, 3);
		// Fast mode with a tiny top: the counter wraps at top, A at full duty,
		// B at half, and a held tick at the end.
		program_timer(16'd3, 16'd100, 16'd50, 16'(dcpwm_pkg::MODE_FAST), 16'd0, 16'd3,
			16'(dcpwm_pkg::PSC_DIV1));
		run_ticks(8'b0001_1111, 6);
		// Phase correct with an over-range duty write that clamps, inverted
		// outputs and B disabled; the counter turns at top and descends.
		program_timer(16'd2, 16'd127, 16'd0, 16'(MODE_PHASE), 16'd1, 16'd1,
			16'(dcpwm_pkg::PSC_DIV1));
		run_ticks(8'b0011_1111, 6);
		// Spare mode code with a zero top under a divide-by-eight prescaler.
		program_timer(16'd0, 16'd50, 16'd100, 16'(MODE_SPARE), 16'd0, 16'd2,
			16'(dcpwm_pkg::PSC_DIV8));
		run_ticks(8'b0001_1111, 5);
		// Largest top with a spare prescaler code, which keeps the timer stopped.
		program_timer(16'hFFFF, 16'd100, 16'd1, 16'(MODE_PHASE_FREQ), 16'd1, 16'd3,
			16'(PSC_SPARE7));
		run_ticks(8'b0000_0111, 3);

		// Random settings, each drained before the next is written. Idling is
		// switched per setting and dropped altogether near the end.
		while (random_ticks < RANDOM_TICKS) begin
			idle_on = (random_ticks < RANDOM_TICKS - 300) && ($urandom_range(0, 3) != 0);
			random_phase($urandom_range(10, 80));
		end
		idle_on = 1'b0;

		// Run the counter up under a moderate top, then drop top below the
		// count: fast mode must keep counting up past the new top.
		program_timer(16'd200, 16'd30, 16'd70, 16'(dcpwm_pkg::MODE_FAST), 16'd0, 16'd3,
			16'(dcpwm_pkg::PSC_DIV1));
		sweep_len = 16'd120;
		for (int i = 0; i < int'(sweep_len); i++)
			send_tick(1'b1);
		program_timer(16'd10, 16'd50, 16'd100, 16'(dcpwm_pkg::MODE_FAST), 16'd1, 16'd3,
			16'(dcpwm_pkg::PSC_DIV1));
		run_ticks(8'hFF, 8);
		run_ticks(8'hFF, 8);
		run_ticks(8'hFF, 8);
		run_ticks(8'hFF, 8);

		wait_idle();
		$display("%0d ticks over %0d register settings, %0d result beats compared",
			ticks_sent, settings, timer_sb.checked);
		$display("a %0d-tick run under a raised top ended with the top lowered below the count",
			sweep_len);
		if (timer_sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> dual_channel_pwm_generator.f
rtl/dcpwm_pkg.sv
rtl/dcpwm_compare.sv
rtl/dual_channel_pwm_generator.sv
tb/sv/tb.sv
